FILE: hdl/smm_pkg.sv
package smm_pkg;

  // sizes of the weight store and the accumulator bank
  localparam int MAX_INNER = 1024;
  localparam int MAX_COLS  = 16;

  localparam int K_W      = $clog2(MAX_INNER);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int WADDR_W  = K_W + COL_W;
  localparam int WT_DEPTH = MAX_INNER * MAX_COLS;

  // configuration register widths, wide enough to hold the limits themselves
  localparam int INNER_W = 11;
  localparam int COLS_W  = 5;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  // arithmetic widths: Q4.12 operands, Q8.24 products, Q24.24 sums
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 48;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 1'b1;

  // opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_STREAM = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [9:0]              row_index;
    logic [3:0]              col_index;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
  } smm_in_t;

  typedef struct packed {
    logic [3:0]              out_col;
    logic signed [ACC_W-1:0] dot_sum;
    logic                    last;
  } smm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } smm_state_t;

endpackage

FILE: hdl/streamed_matrix_multiply_unit.sv
// Streamed dense matrix multiply, C = A x B, signed Q4.12 in, Q24.24 out.
// Input channel (in_valid/in_ready/in_data) carries one word per element:
// a load word writes one weight B[k][j] into the weight RAM, a stream word
// carries element a_k of the current row of A. Results leave on the output
// channel (out_valid/out_ready/out_data), one word per column, the final
// one of the row marked with last. inner_len and out_cols are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while
// the block is idle, which the block does not enforce. Load words are taken
// back to back while idle. A stream word does one multiply-accumulate
// per cycle through the single MAC, then the three-stage
// read/multiply/write-back pipeline on the accumulator RAM drains before
// the next word is taken. A row end then emits one word per effective
// column (out_cols, at most 16) through the accumulator RAM read and then
// the output register, one word at a time and only while it is free.
// Reset clears the configuration to 1 and 1, empties the pipeline and marks
// all accumulators zero; the weight RAM is not cleared and must be loaded
// before use. A stalled receiver holds the output register; emission waits
// and input is refused until the row is out, while a finished last result
// may wait in the output register as the next word is taken.
module streamed_matrix_multiply_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  smm_pkg::smm_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output smm_pkg::smm_out_t                     out_data,
  input  logic                                  cfg_we,
  input  logic [smm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [smm_pkg::CFG_W-1:0]             cfg_wdata
);
  import smm_pkg::*;

  smm_state_t state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;

  logic [INNER_W-1:0] inner_len_r;
  logic [COLS_W-1:0]  out_cols_r;
  logic [INNER_W-1:0] ni;
  logic [COLS_W-1:0]  nc;
  logic [COL_W-1:0]   col_last;

  logic [K_W-1:0]          k_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    end_r;

  logic signed [VAL_W-1:0] wt_mem [WT_DEPTH];
  logic signed [VAL_W-1:0] wt_rdata_r;
  logic signed [ACC_W-1:0] acc_mem [MAX_COLS];
  logic signed [ACC_W-1:0] acc_rdata_r;
  logic [MAX_COLS-1:0]     acc_vld_r;

  logic                     p1_vld_r, p2_vld_r;
  logic [COL_W-1:0]         p1_col_r, p2_col_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  accq_r;
  logic signed [ACC_W:0]    sum_full;
  logic signed [ACC_W-1:0]  sum_sat;

  logic             e1_vld_r, e1_last_r, e1_live_r;
  logic [COL_W-1:0] e1_col_r;

  logic     out_valid_r;
  smm_out_t out_data_r;

  logic in_fire, k_ok, j_ok, is_stream, load_we;
  logic out_free, mac_issue, emit_issue, clear_all, at_last;

  // effective limits
  always_comb begin
    ni = (inner_len_r > INNER_W'(MAX_INNER)) ? INNER_W'(MAX_INNER) : inner_len_r;
    nc = (out_cols_r > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : out_cols_r;
    col_last = COL_W'(nc - COLS_W'(1));
  end

  // input word decode
  assign in_fire   = in_valid && in_ready;
  assign is_stream = (in_data.opcode == OP_STREAM);
  assign k_ok      = ({1'b0, in_data.row_index} < ni);
  assign j_ok      = ({1'b0, in_data.col_index} < nc);
  assign load_we   = in_fire && !is_stream && k_ok && j_ok;
  assign out_free  = !out_valid_r || out_ready;
  assign at_last   = (col_r == col_last);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_stream && (nc != '0)) begin
          if (k_ok) begin
            state_nxt = ST_MAC;
          end else if (in_data.row_end) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MAC: begin
        if (at_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = end_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_issue && at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    mac_issue  = 1'b0;
    emit_issue = 1'b0;
    col_nxt    = col_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = !p1_vld_r && !p2_vld_r && !e1_vld_r;
        col_nxt  = '0;
      end
      ST_MAC: begin
        mac_issue = 1'b1;
        col_nxt   = col_r + COL_W'(1);
      end
      ST_DRAIN: begin
        col_nxt = '0;
      end
      ST_EMIT: begin
        emit_issue = !e1_vld_r && out_free;
        if (emit_issue) begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      default: col_nxt = '0;
    endcase
    clear_all = (emit_issue && at_last) ||
                (in_fire && is_stream && in_data.row_end && (nc == '0));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      inner_len_r <= INNER_W'(1);
      out_cols_r  <= COLS_W'(1);
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      e1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_vld_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      p1_vld_r <= mac_issue;
      p2_vld_r <= p1_vld_r;
      e1_vld_r <= emit_issue;
      if (e1_vld_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (clear_all) begin
        acc_vld_r <= '0;
      end else if (p2_vld_r) begin
        acc_vld_r[p2_col_r] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INNER_LEN: inner_len_r <= cfg_wdata[INNER_W-1:0];
          CFG_OUT_COLS:  out_cols_r  <= cfg_wdata[COLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // latched stream word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      k_r   <= in_data.row_index;
      val_r <= in_data.value;
      end_r <= in_data.row_end;
    end
  end

  // weight RAM: written by load words, read by the MAC sequencer
  always_ff @(posedge clk) begin
    if (load_we) begin
      wt_mem[{in_data.row_index, in_data.col_index}] <= in_data.value;
    end
    wt_rdata_r <= wt_mem[{k_r, col_r}];
  end

  // accumulator RAM: read at the current column, written back from the adder
  always_ff @(posedge clk) begin
    if (p2_vld_r) begin
      acc_mem[p2_col_r] <= sum_sat;
    end
    acc_rdata_r <= acc_mem[col_r];
  end

  // multiply stage, accumulators not yet written since a clear read as zero
  always_ff @(posedge clk) begin
    p1_col_r <= col_r;
    p2_col_r <= p1_col_r;
    prod_r   <= PROD_W'(val_r * wt_rdata_r);
    accq_r   <= acc_vld_r[p1_col_r] ? acc_rdata_r : '0;
  end

  // saturating accumulate
  always_comb begin
    sum_full = {accq_r[ACC_W-1], accq_r} +
               {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (sum_full[ACC_W] != sum_full[ACC_W-1]) begin
      sum_sat = sum_full[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_full[ACC_W-1:0];
    end
  end

  // emission read stage and output register
  always_ff @(posedge clk) begin
    e1_col_r  <= col_r;
    e1_last_r <= at_last;
    e1_live_r <= acc_vld_r[col_r];
    if (e1_vld_r) begin
      out_data_r.out_col <= e1_col_r;
      out_data_r.dot_sum <= e1_live_r ? acc_rdata_r : '0;
      out_data_r.last    <= e1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/smm_checker.sv
module smm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input smm_pkg::smm_out_t out_data
);
  import smm_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a new result is only loaded while input is refused
  a_rise_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input was open");

  // a row that is still being emitted keeps the input closed
  a_row_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input open in the middle of a result row");

endmodule

bind streamed_matrix_multiply_unit smm_checker u_smm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: verif/tb.sv
module tb;
  import smm_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 200000;

  // running copy of the multiplier: weights, column sums and the sums it owes
  class matmul_scoreboard;
    logic signed [VAL_W-1:0] b_weights [WT_DEPTH];
    bit                      b_loaded  [WT_DEPTH];
    logic signed [ACC_W-1:0] col_acc   [MAX_COLS];
    logic [INNER_W-1:0]      inner_len;
    logic [COLS_W-1:0]       out_cols;
    smm_out_t                sums_due [$];
    int                      errors;

    function new();
      int i;
      for (i = 0; i < WT_DEPTH; i++) begin
        b_weights[i] = '0;
        b_loaded[i]  = 1'b0;
      end
      for (i = 0; i < MAX_COLS; i++) col_acc[i] = '0;
      inner_len = INNER_W'(1);
      out_cols  = COLS_W'(1);
      errors    = 0;
    endfunction

    function void set_config(int inner, int cols);
      inner_len = INNER_W'(inner);
      out_cols  = COLS_W'(cols);
    endfunction

    // register values above the store size act as the store size
    function int eff_inner();
      return (int'(inner_len) > MAX_INNER) ? MAX_INNER : int'(inner_len);
    endfunction

    function int eff_cols();
      return (int'(out_cols) > MAX_COLS) ? MAX_COLS : int'(out_cols);
    endfunction

    // an element at position k reads only weights that were loaded
    function bit safe_position(int k);
      int c;
      if (k >= eff_inner()) return 1'b1;
      for (c = 0; c < eff_cols(); c++)
        if (!b_loaded[k * MAX_COLS + c]) return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    // apply one accepted input word, queue the sums of a closed row
    function void note_word(smm_in_t w);
      int       ni, nc, k, j, c;
      longint   s;
      smm_out_t r;
      logic signed [PROD_W-1:0] prod;
      ni = eff_inner();
      nc = eff_cols();
      k  = int'(w.row_index);
      j  = int'(w.col_index);
      if (w.opcode == OP_LOAD) begin
        if (k < ni && j < nc) begin
          b_weights[k * MAX_COLS + j] = w.value;
          b_loaded[k * MAX_COLS + j]  = 1'b1;
        end
        return;
      end
      if (k < ni) begin
        for (c = 0; c < nc; c++) begin
          prod = PROD_W'(w.value * b_weights[k * MAX_COLS + c]);
          s = longint'(col_acc[c]) + longint'(prod);
          // saturate at the 48-bit bounds
          if (s > longint'(ACC_MAX)) s = longint'(ACC_MAX);
          if (s < longint'(ACC_MIN)) s = longint'(ACC_MIN);
          col_acc[c] = s[ACC_W-1:0];
        end
      end
      if (!w.row_end) return;
      for (c = 0; c < nc; c++) begin
        r.out_col = 4'(c);
        r.dot_sum = col_acc[c];
        r.last    = (c == nc - 1);
        sums_due.push_back(r);
      end
      for (c = 0; c < MAX_COLS; c++) col_acc[c] = '0;
    endfunction

    function void check_sum_word(smm_out_t got);
      smm_out_t want;
      if (sums_due.size() == 0) begin
        $error("result word with no sum due: out_col %0d dot_sum %0d last %0d",
               got.out_col, got.dot_sum, got.last);
        errors++;
        return;
      end
      want = sums_due.pop_front();
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        errors++;
      end
      if (got.dot_sum !== want.dot_sum) begin
        $error("dot_sum: expected %0d, got %0d", want.dot_sum, got.dot_sum);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  smm_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  smm_out_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_INNER_LEN;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  matmul_scoreboard board;
  int               ready_rows [$];
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               hold_token     = 0;
  int               hold_seen      = 0;
  int               hold_left      = 0;

  streamed_matrix_multiply_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // result side: check accepted words, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_sum_word(out_data);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  function automatic smm_in_t make_word(logic op, int k, int j, int v, bit row_end);
    smm_in_t w;
    w.opcode    = op;
    w.row_index = 10'(k);
    w.col_index = 4'(j);
    w.value     = 16'(v);
    w.row_end   = row_end;
    return w;
  endfunction

  // element values with the extremes well represented
  function automatic int rand_value();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(65535));
    endcase
  endfunction

  // position of an A element: reads only loaded weights once a row is loaded
  function automatic int pick_position();
    int k;
    k = int'($urandom_range(1023));
    if (ready_rows.size() != 0 && ($urandom_range(4) != 0 || !board.safe_position(k)))
      k = ready_rows[$urandom_range(ready_rows.size() - 1)];
    return k;
  endfunction

  // offer one word, idling first at random, and wait for the handshake
  task automatic send_word(input smm_in_t w);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(w);
  endtask

  // stop offering, wait for every owed sum and let the block finish
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int inner, input int cols);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INNER_LEN;
    cfg_wdata <= CFG_W'(inner);
    @(posedge clk);
    cfg_index <= CFG_OUT_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_config(inner, cols);
    ready_rows.delete();
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // load whole B rows: row 0 first, then the last position, then random ones
  task automatic load_rows(input int n_rows);
    int ni, nc, r, c, k;
    ni = board.eff_inner();
    nc = board.eff_cols();
    if (ni == 0 || nc == 0) return;
    for (r = 0; r < n_rows; r++) begin
      k = (r == 0) ? 0 : (r == 1) ? ni - 1 : int'($urandom_range(ni - 1));
      for (c = 0; c < nc; c++) send_word(make_word(OP_LOAD, k, c, rand_value(), 1'b0));
      ready_rows.push_back(k);
    end
  endtask

  // extremes, out-of-range loads and elements, row end on a load
  task automatic directed_words();
    send_word(make_word(OP_LOAD, 0, 0, -32768, 1'b0));
    send_word(make_word(OP_LOAD, 0, 1, 32767, 1'b0));
    send_word(make_word(OP_LOAD, 0, 2, 1, 1'b0));
    send_word(make_word(OP_LOAD, 1, 0, 32767, 1'b0));
    send_word(make_word(OP_LOAD, 1, 1, -32768, 1'b0));
    send_word(make_word(OP_LOAD, 1, 2, -1, 1'b0));
    send_word(make_word(OP_LOAD, 2, 0, 16'h1234, 1'b0));
    send_word(make_word(OP_LOAD, 0, 3, 16'h4321, 1'b0));
    send_word(make_word(OP_LOAD, 1, 2, 16'h0800, 1'b1));
    send_word(make_word(OP_STREAM, 0, 15, -32768, 1'b0));
    send_word(make_word(OP_STREAM, 1, 0, 32767, 1'b1));
    send_word(make_word(OP_STREAM, 1023, 15, 32767, 1'b1));
    send_word(make_word(OP_STREAM, 0, 7, 32767, 1'b0));
    send_word(make_word(OP_STREAM, 2, 0, 16'h1111, 1'b0));
    send_word(make_word(OP_STREAM, 1, 3, -1, 1'b1));
    send_word(make_word(OP_STREAM, 0, 0, 0, 1'b1));
  endtask

  // rows of random length, stray loads, now and then a row left open
  task automatic random_words(input int n_words, input bit with_hold);
    int sent, len, e;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < n_words) begin
      if (with_hold && !held && sent >= n_words / 2) begin
        hold_token++;
        held = 1'b1;
        // close a row at once so its results back up behind the held receiver
        send_word(make_word(OP_STREAM, pick_position(), 0, rand_value(), 1'b1));
        sent++;
      end
      if ($urandom_range(99) < 15) begin
        send_word(make_word(OP_LOAD, int'($urandom_range(1023)), int'($urandom_range(15)),
                            rand_value(), 1'($urandom_range(1))));
        sent++;
      end else begin
        len = int'($urandom_range(6, 1));
        for (e = 0; e < len; e++)
          send_word(make_word(OP_STREAM, pick_position(), int'($urandom_range(15)),
                              rand_value(), (e == len - 1) && ($urandom_range(9) != 0)));
        sent += len;
      end
    end
  endtask

  task automatic random_phase(input int inner, input int cols, input int send_pct,
                              input int recv_pct, input int n_rows, input int n_words,
                              input bit with_hold);
    configure(inner, cols);
    set_idling(send_pct, recv_pct);
    load_rows(n_rows);
    random_words(n_words, with_hold);
  endtask

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    configure(2, 3);
    directed_words();

    random_phase(1, 1, 0, 0, 3, 8, 1'b0);
    random_phase(1024, 2, 51, 0, 2, 10, 1'b0);
    random_phase(2047, 31, 0, 51, 1, 12, 1'b1);
    random_phase(0, 5, 22, 22, 1, 6, 1'b0);
    random_phase(6, 0, 0, 0, 1, 6, 1'b0);
    random_phase(int'($urandom_range(40, 2)), int'($urandom_range(4, 2)), 22, 22, 2, 10,
                 1'b0);

    settle();
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/smm_pkg.sv
hdl/streamed_matrix_multiply_unit.sv
hdl/smm_checker.sv
verif/tb.sv
